// ===== rtl/sclc_pkg.sv =====
// ----------------------------------------------------------------------------
// sclc_pkg: shared types and constants for the sector cache tag store
// Token and write-back types for the entry cell chain, media geometry tables
// and the reciprocal constants used by the cylinder/head/sector split.
// ----------------------------------------------------------------------------
package sclc_pkg;

  // Storage sizing
  localparam int ENTRIES_DEF = 32;
  localparam int MAX_ENTRIES = 256;
  localparam int WAY_W       = $clog2(MAX_ENTRIES);
  localparam int OUT_WAY_W   = 5;
  localparam int STAMP_W     = 32;
  localparam int LBA_W       = 16;
  localparam int TYPE_W      = 4;
  localparam int SPT_W       = 6;
  localparam int CYL_W       = 12;
  localparam int QUOT_W      = 13;

  // Reciprocal scaling: exact quotient for all 16-bit dividends and the divisors 9, 15, 18 and 36
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = LBA_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_9  = RECIP_W'((2**RECIP_SHIFT + 9 - 1) / 9);
  localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'((2**RECIP_SHIFT + 15 - 1) / 15);
  localparam logic [RECIP_W-1:0] RECIP_18 = RECIP_W'((2**RECIP_SHIFT + 18 - 1) / 18);
  localparam logic [RECIP_W-1:0] RECIP_36 = RECIP_W'((2**RECIP_SHIFT + 36 - 1) / 36);

  // Operation codes
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_DRIVE = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DRIVE0 = 1'b0,
    CFG_DRIVE1 = 1'b1
  } cfg_reg_e;

  // Media type codes
  localparam logic [TYPE_W-1:0] MEDIA_NONE = 4'd0;
  localparam logic [TYPE_W-1:0] MEDIA_T1   = 4'd1;
  localparam logic [TYPE_W-1:0] MEDIA_T2   = 4'd2;
  localparam logic [TYPE_W-1:0] MEDIA_T3   = 4'd3;
  localparam logic [TYPE_W-1:0] MEDIA_T4   = 4'd4;
  localparam logic [TYPE_W-1:0] MEDIA_T5   = 4'd5;

  // Request token that walks down the cell chain
  typedef struct packed {
    logic               active;
    logic               op;
    logic               disk;
    logic [LBA_W-1:0]   lba;
    logic               hit;
    logic [WAY_W-1:0]   hit_way;
    logic               has_free;
    logic [WAY_W-1:0]   free_way;
    logic [WAY_W-1:0]   best_way;
    logic [STAMP_W-1:0] best_stamp;
  } token_t;

  // Write-back broadcast to all cells
  typedef struct packed {
    logic               en;
    logic               set_tag;
    logic [WAY_W-1:0]   way;
    logic               disk;
    logic [LBA_W-1:0]   sector;
    logic [STAMP_W-1:0] stamp;
  } wr_t;

  // Geometry result of the drive lookup
  typedef struct packed {
    status_e            status;
    logic [CYL_W-1:0]   cylinder;
    logic               head;
    logic [SPT_W-1:0]   sector_number;
    logic [SPT_W-1:0]   sectors_per_track;
  } geom_t;

  // Sectors per track of a media type; zero for none or unknown
  function automatic logic [SPT_W-1:0] spt_of(logic [TYPE_W-1:0] media);
    logic [SPT_W-1:0] spt;
    case (media)
      MEDIA_T1: spt = 6'd9;
      MEDIA_T2: spt = 6'd15;
      MEDIA_T3: spt = 6'd9;
      MEDIA_T4: spt = 6'd18;
      MEDIA_T5: spt = 6'd36;
      default:  spt = '0;
    endcase
    return spt;
  endfunction

  // Scaled reciprocal of the track length of a media type
  function automatic logic [RECIP_W-1:0] recip_of(logic [TYPE_W-1:0] media);
    logic [RECIP_W-1:0] m;
    case (media)
      MEDIA_T1: m = RECIP_9;
      MEDIA_T2: m = RECIP_15;
      MEDIA_T3: m = RECIP_9;
      MEDIA_T4: m = RECIP_18;
      MEDIA_T5: m = RECIP_36;
      default:  m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/sclc_cell.sv =====
// ----------------------------------------------------------------------------
// sclc_cell: one entry of the tag store
// Holds one tag and stamp, folds its entry into the passing request token
// (first match, first free way, oldest stamp) and registers the token on.
// ----------------------------------------------------------------------------
module sclc_cell
  import sclc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  token_t tok_i,
  input  wr_t    wr_i,
  output token_t tok_o
);

  localparam logic [WAY_W-1:0] MY_WAY = WAY_W'(IDX);
  localparam bit               FIRST  = (IDX == 0);

  logic               valid_q;
  logic               disk_q;
  logic [LBA_W-1:0]   sector_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               active_q;
  token_t             tok_d, tok_q;
  logic               match, older, wr_sel;

  // Fold this entry into the token
  always_comb begin
    match  = valid_q && (disk_q == tok_i.disk) && (sector_q == tok_i.lba);
    older  = valid_q && (FIRST || (stamp_q < tok_i.best_stamp));
    tok_d  = tok_i;
    if (match && !tok_i.hit) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_way = MY_WAY;
    end
    if (!valid_q && !tok_i.has_free) begin
      tok_d.has_free = 1'b1;
      tok_d.free_way = MY_WAY;
    end
    if (older) begin
      tok_d.best_way   = MY_WAY;
      tok_d.best_stamp = stamp_q;
    end
  end

  assign wr_sel = wr_i.en && (wr_i.way == MY_WAY);

  // Hand the token to the neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= tok_i.active;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  // Take the payload from the token register, the marker from the reset flop
  always_comb begin
    tok_o        = tok_q;
    tok_o.active = active_q;
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_sel && wr_i.set_tag) begin
      valid_q <= 1'b1;
    end
  end

  // Tag and stamp update on write-back
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      stamp_q <= wr_i.stamp;
      if (wr_i.set_tag) begin
        disk_q   <= wr_i.disk;
        sector_q <= wr_i.sector;
      end
    end
  end

endmodule

// ===== rtl/sclc_geom.sv =====
// ----------------------------------------------------------------------------
// sclc_geom: linear sector to cylinder/head/sector conversion
// Multiplies by the scaled reciprocal of the track length, registers the
// quotient, then forms the remainder and the media status.
// ----------------------------------------------------------------------------
module sclc_geom
  import sclc_pkg::*;
(
  input  logic              clk_i,
  input  logic [LBA_W-1:0]  lba_i,
  input  logic [TYPE_W-1:0] media_i,
  output geom_t             geom_o
);

  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot_q;
  logic [LBA_W-1:0]    lba_q;
  logic [SPT_W-1:0]    spt_q;
  logic [TYPE_W-1:0]   media_q;
  logic [QUOT_W+SPT_W-1:0] back;
  logic [LBA_W-1:0]    rem;

  assign prod = PROD_W'(lba_i) * PROD_W'(recip_of(media_i));

  // Register the quotient
  always_ff @(posedge clk_i) begin
    quot_q  <= prod[RECIP_SHIFT +: QUOT_W];
    lba_q   <= lba_i;
    spt_q   <= spt_of(media_i);
    media_q <= media_i;
  end

  // Remainder, then assemble the geometry
  always_comb begin
    back   = (QUOT_W+SPT_W)'(quot_q) * (QUOT_W+SPT_W)'(spt_q);
    rem    = lba_q - back[LBA_W-1:0];
    geom_o = '0;
    if (media_q == MEDIA_NONE) begin
      geom_o.status = ST_NO_DRIVE;
    end else if (spt_q == '0) begin
      geom_o.status = ST_UNKNOWN;
    end else begin
      geom_o.status            = ST_OK;
      geom_o.cylinder          = quot_q[QUOT_W-1:1];
      geom_o.head              = quot_q[0];
      geom_o.sector_number     = rem[SPT_W-1:0] + SPT_W'(1);
      geom_o.sectors_per_track = spt_q;
    end
  end

endmodule

// ===== rtl/sector_cache_lru_chs.sv =====
// ----------------------------------------------------------------------------
// sector_cache_lru_chs: fully associative LRU tag store for a floppy sector cache
// Lookup and fill on disk/sector tags, with CHS conversion on a lookup miss.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a clock edge with start high and busy low; opcode_i
//   selects lookup or fill, disk_i and lba_i give the tag. The request walks
//   a chain of ENTRIES cells, one cell per cycle, collecting the first match,
//   the first free way and the oldest stamp. As the token leaves the last
//   cell the chosen entry is written back and the result is shown for a
//   single cycle with done_o.
//   done_o rises as the token leaves the last cell and busy falls with it,
//   so a new request can be taken at the edge that ends the done_o cycle;
//   only one request is in the chain at a time. The result transfer cannot
//   be held off by the receiver; done_o marks it for exactly one cycle.
//   Drive media types are written through cfg_we_i/cfg_idx_i/cfg_data_i;
//   the user must write them only while busy is low, which the block itself
//   does not enforce. Reset clears all valid bits at once, sets the access
//   counter to one and both media types to none; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sector_cache_lru_chs
  import sclc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [TYPE_W-1:0]    cfg_data_i,
  // Request
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode_i,
  input  logic                 disk_i,
  input  logic [LBA_W-1:0]     lba_i,
  // Result
  output logic                 done_o,
  output logic                 hit_o,
  output logic [OUT_WAY_W-1:0] way_o,
  output logic [1:0]           status_o,
  output logic [CYL_W-1:0]     cylinder_o,
  output logic                 head_o,
  output logic [SPT_W-1:0]     sector_number_o,
  output logic [SPT_W-1:0]     sectors_per_track_o
);

  logic [TYPE_W-1:0]  drive0_type_q, drive1_type_q;
  logic [TYPE_W-1:0]  media_q;
  logic [LBA_W-1:0]   lba_q;
  logic               busy_q;
  logic               done_q;
  logic [STAMP_W-1:0] cnt_q, cnt_d;
  logic               accept;
  token_t             tok [ENTRIES+1];
  token_t             last;
  wr_t                wr;
  geom_t              geom;
  logic [ENTRIES-1:0] act_vec;
  logic               lk_hit, is_fill;
  logic [WAY_W-1:0]   victim;

  logic               hit_q;
  logic [OUT_WAY_W-1:0] way_q;
  status_e            status_q;
  logic [CYL_W-1:0]   cyl_q;
  logic               head_q;
  logic [SPT_W-1:0]   sec_q, spt_q;

  assign accept = start && !busy_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive0_type_q <= MEDIA_NONE;
      drive1_type_q <= MEDIA_NONE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DRIVE0: drive0_type_q <= cfg_data_i;
        CFG_DRIVE1: drive1_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the request for the geometry unit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lba_q   <= lba_i;
      media_q <= disk_i ? drive1_type_q : drive0_type_q;
    end
  end

  sclc_geom u_geom (
    .clk_i   (clk_i),
    .lba_i   (lba_q),
    .media_i (media_q),
    .geom_o  (geom)
  );

  // Inject the request token at the head of the chain
  always_comb begin
    tok[0]            = '0;
    tok[0].active     = accept;
    tok[0].op         = opcode_i;
    tok[0].disk       = disk_i;
    tok[0].lba        = lba_i;
    tok[0].best_stamp = '1;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    sclc_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .wr_i   (wr),
      .tok_o  (tok[g+1])
    );
    assign act_vec[g] = tok[g+1].active;
  end

  assign last = tok[ENTRIES];

  // Decide the result and the write-back
  always_comb begin
    is_fill = (op_e'(last.op) == OP_FILL);
    lk_hit  = !is_fill && last.hit;
    victim  = last.has_free ? last.free_way : last.best_way;
    wr         = '0;
    wr.en      = last.active && (is_fill || lk_hit);
    wr.set_tag = is_fill;
    wr.way     = is_fill ? victim : last.hit_way;
    wr.disk    = last.disk;
    wr.sector  = last.lba;
    wr.stamp   = cnt_q;
    cnt_d      = (cnt_q == '1) ? cnt_q : cnt_q + STAMP_W'(1);
  end

  // Control: busy, strobe, access counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= STAMP_W'(1);
    end else begin
      done_q <= last.active;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last.active) begin
        busy_q <= 1'b0;
      end
      if (wr.en) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (last.active) begin
      hit_q    <= lk_hit;
      way_q    <= '0;
      status_q <= ST_OK;
      cyl_q    <= '0;
      head_q   <= 1'b0;
      sec_q    <= '0;
      spt_q    <= '0;
      if (is_fill) begin
        way_q <= victim[OUT_WAY_W-1:0];
      end else if (lk_hit) begin
        way_q <= last.hit_way[OUT_WAY_W-1:0];
      end else begin
        status_q <= geom.status;
        cyl_q    <= geom.cylinder;
        head_q   <= geom.head;
        sec_q    <= geom.sector_number;
        spt_q    <= geom.sectors_per_track;
      end
    end
  end

  assign busy                = busy_q;
  assign done_o              = done_q;
  assign hit_o               = hit_q;
  assign way_o               = way_q;
  assign status_o            = status_q;
  assign cylinder_o          = cyl_q;
  assign head_o              = head_q;
  assign sector_number_o     = sec_q;
  assign sectors_per_track_o = spt_q;

`ifndef ASSERT_OFF
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_vec))
    else $error("more than one request token in the cell chain");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after a request transfer");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result strobe while still busy");

  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hit_q) |-> (status_q == ST_OK))
    else $error("hit reported with a drive error status");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0)
    else $error("access counter wrapped to zero");
`endif

endmodule

// ===== verif/tb_sector_cache_lru_chs.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sector_cache_lru_chs: self-checking bench for the sector cache tag store
// Feeds lookups and fills through the start/busy port and changes both drive
// media types between phases. A cycle-free model of the tag store tracks
// tags, stamps and replacement, and every done_o result is checked field by
// field against it.
// ----------------------------------------------------------------------------
module tb_sector_cache_lru_chs
  import sclc_pkg::*;
();

  localparam int          WAYS          = ENTRIES_DEF;
  localparam int          TAIL_ITEMS    = 100;    // last items go without idling
  localparam int          PHASE_ITEMS   = 145;
  localparam int          POOL_DEPTH    = 48;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // Pending work for the driver: a request or a register write
  typedef enum logic {
    PEND_REQ,
    PEND_CFG
  } pend_kind_e;

  typedef struct {
    pend_kind_e        kind;
    op_e               op;
    logic              disk;
    logic [LBA_W-1:0]  lba;
    cfg_reg_e          idx;
    logic [TYPE_W-1:0] data;
  } pend_t;

  // One result as the block reports it
  typedef struct packed {
    logic                 hit;
    logic [OUT_WAY_W-1:0] way;
    status_e              status;
    logic [CYL_W-1:0]     cylinder;
    logic                 head;
    logic [SPT_W-1:0]     sector_number;
    logic [SPT_W-1:0]     sectors_per_track;
  } chs_result_t;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 cfg_we_i   = 1'b0;
  logic [0:0]           cfg_idx_i  = '0;
  logic [TYPE_W-1:0]    cfg_data_i = '0;
  logic                 start      = 1'b0;
  logic                 busy;
  logic                 opcode_i   = 1'b0;
  logic                 disk_i     = 1'b0;
  logic [LBA_W-1:0]     lba_i      = '0;
  logic                 done_o;
  logic                 hit_o;
  logic [OUT_WAY_W-1:0] way_o;
  logic [1:0]           status_o;
  logic [CYL_W-1:0]     cylinder_o;
  logic                 head_o;
  logic [SPT_W-1:0]     sector_number_o;
  logic [SPT_W-1:0]     sectors_per_track_o;

  sector_cache_lru_chs #(
    .ENTRIES(WAYS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .disk_i             (disk_i),
    .lba_i              (lba_i),
    .done_o             (done_o),
    .hit_o              (hit_o),
    .way_o              (way_o),
    .status_o           (status_o),
    .cylinder_o         (cylinder_o),
    .head_o             (head_o),
    .sector_number_o    (sector_number_o),
    .sectors_per_track_o(sectors_per_track_o)
  );

  // Clock and a single reset pulse
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Tag store model
  // --------------------------------------------------------------------------
  logic                tag_valid [WAYS];
  logic                tag_disk  [WAYS];
  logic [LBA_W-1:0]    tag_lba   [WAYS];
  logic [STAMP_W-1:0]  tag_stamp [WAYS];
  logic [STAMP_W-1:0]  stamp_ctr = 32'd1;
  logic [TYPE_W-1:0]   drive0_media = MEDIA_NONE;
  logic [TYPE_W-1:0]   drive1_media = MEDIA_NONE;

  pend_t       pend_q   [$];
  chs_result_t result_q [$];
  int unsigned error_n = 0;

  initial begin
    for (int i = 0; i < WAYS; i++) begin
      tag_valid[i] = 1'b0;
      tag_disk[i]  = 1'b0;
      tag_lba[i]   = '0;
      tag_stamp[i] = '0;
    end
  end

  // Hand out the current access count; it sticks at all ones
  function automatic logic [STAMP_W-1:0] next_stamp();
    logic [STAMP_W-1:0] s;
    s = stamp_ctr;
    if (stamp_ctr != '1) stamp_ctr = stamp_ctr + 1'b1;
    return s;
  endfunction

  // Apply one request to the model and return what the block must report
  function automatic chs_result_t cache_access(op_e op, logic disk, logic [LBA_W-1:0] lba);
    chs_result_t       r;
    int                victim;
    bit                free_seen;
    logic [TYPE_W-1:0] media;
    int unsigned       spt;
    r = '0;
    r.status = ST_OK;
    if (op == OP_LOOKUP) begin
      // lowest matching way wins when a tag is present twice
      for (int i = 0; i < WAYS; i++) begin
        if (!r.hit && tag_valid[i] && tag_disk[i] == disk && tag_lba[i] == lba) begin
          r.hit = 1'b1;
          r.way = i[OUT_WAY_W-1:0];
          tag_stamp[i] = next_stamp();
        end
      end
      if (!r.hit) begin
        media = disk ? drive1_media : drive0_media;
        case (media)
          MEDIA_T1, MEDIA_T3: spt = 9;
          MEDIA_T2:           spt = 15;
          MEDIA_T4:           spt = 18;
          MEDIA_T5:           spt = 36;
          default:            spt = 0;
        endcase
        if (media == MEDIA_NONE) begin
          r.status = ST_NO_DRIVE;
        end else if (spt == 0) begin
          r.status = ST_UNKNOWN;
        end else begin
          r.cylinder          = CYL_W'(lba / (2 * spt));
          r.head              = 1'((lba / spt) % 2);
          r.sector_number     = SPT_W'(lba % spt + 1);
          r.sectors_per_track = SPT_W'(spt);
        end
      end
    end else begin
      // first free way, else oldest stamp with the lowest index on a tie
      victim    = 0;
      free_seen = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!free_seen && !tag_valid[i]) begin
          victim    = i;
          free_seen = 1'b1;
        end
      end
      if (!free_seen) begin
        for (int i = 1; i < WAYS; i++) begin
          if (tag_stamp[i] < tag_stamp[victim]) victim = i;
        end
      end
      tag_valid[victim] = 1'b1;
      tag_disk[victim]  = disk;
      tag_lba[victim]   = lba;
      tag_stamp[victim] = next_stamp();
      r.way = victim[OUT_WAY_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  int unsigned gap_n       = 0;
  bit          gap_on_idle = 1'b0;  // count the burst only while busy is low
  int unsigned idle_mode   = 1;
  int unsigned accept_n    = 0;

  // Decide whether to open an idle burst; none near the end of the run
  function automatic bit idle_draw();
    if (pend_q.size() < TAIL_ITEMS) return 1'b0;
    case (idle_mode)
      0:       return 1'b0;
      1:       return $urandom_range(0, 5) == 0;
      default: return $urandom_range(0, 1) == 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    pend_t item;
    logic  req_up;
    logic  we_up;
    if (rst_ni) begin
      req_up = start;
      we_up  = 1'b0;
      // register write lands at this edge
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_DRIVE0) drive0_media = cfg_data_i;
        else drive1_media = cfg_data_i;
      end
      if (gap_n != 0 && (!gap_on_idle || !busy)) gap_n--;
      // request transfer at this edge
      if (start && !busy) begin
        result_q.push_back(cache_access(op_e'(opcode_i), disk_i, lba_i));
        req_up = 1'b0;
        accept_n++;
        if (accept_n % 64 == 0) idle_mode = $urandom_range(0, 2);
        if (idle_draw()) begin
          gap_n       = $urandom_range(1, 13);
          gap_on_idle = 1'($urandom_range(0, 1));
        end
      end
      // present the next piece of work
      if (!req_up && gap_n == 0 && pend_q.size() != 0) begin
        if (pend_q[0].kind == PEND_REQ) begin
          if (idle_draw() && $urandom_range(0, 3) == 0) begin
            gap_n       = $urandom_range(1, 13);
            gap_on_idle = 1'($urandom_range(0, 1));
          end else begin
            item     = pend_q.pop_front();
            opcode_i <= item.op;
            disk_i   <= item.disk;
            lba_i    <= item.lba;
            req_up   = 1'b1;
          end
        end else if (!busy && !done_o && !start && result_q.size() == 0) begin
          // only write registers with nothing in flight
          item       = pend_q.pop_front();
          cfg_idx_i  <= item.idx;
          cfg_data_i <= item.data;
          we_up      = 1'b1;
        end
      end
      start    <= req_up;
      cfg_we_i <= we_up;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_n++;
    end
  endtask

  always @(posedge clk_i) begin
    chs_result_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_n++;
      end else begin
        want = result_q.pop_front();
        check_field("hit", want.hit, hit_o);
        check_field("way", want.way, way_o);
        check_field("status", want.status, status_o);
        check_field("cylinder", want.cylinder, cylinder_o);
        check_field("head", want.head, head_o);
        check_field("sector_number", want.sector_number, sector_number_o);
        check_field("sectors_per_track", want.sectors_per_track, sectors_per_track_o);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic [LBA_W:0] recent_tags [$];  // {disk, lba} of recently used tags
  int unsigned    queued_n = 0;

  task automatic queue_op(op_e op, logic disk, logic [LBA_W-1:0] lba);
    pend_t p;
    p.kind = PEND_REQ;
    p.op   = op;
    p.disk = disk;
    p.lba  = lba;
    p.idx  = CFG_DRIVE0;
    p.data = '0;
    pend_q.push_back(p);
    queued_n++;
  endtask

  task automatic queue_media(logic [TYPE_W-1:0] d0, logic [TYPE_W-1:0] d1);
    pend_t p;
    p.kind = PEND_CFG;
    p.op   = OP_LOOKUP;
    p.disk = 1'b0;
    p.lba  = '0;
    p.idx  = CFG_DRIVE0;
    p.data = d0;
    pend_q.push_back(p);
    p.idx  = CFG_DRIVE1;
    p.data = d1;
    pend_q.push_back(p);
  endtask

  function automatic logic [LBA_W-1:0] pick_lba();
    if ($urandom_range(0, 1) == 0) return LBA_W'($urandom_range(0, 95));
    return LBA_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic remember_tag(logic disk, logic [LBA_W-1:0] lba);
    recent_tags.push_back({disk, lba});
    if (recent_tags.size() > POOL_DEPTH) void'(recent_tags.pop_front());
  endtask

  initial begin
    int unsigned      phase_items;
    int unsigned      roll;
    logic [TYPE_W-1:0] d0;
    logic [TYPE_W-1:0] d1;
    logic             disk;
    logic [LBA_W-1:0] lba;
    logic [LBA_W:0]   tag;

    // directed: geometry extremes, missing drive, duplicates, disk compare
    queue_media(MEDIA_T1, MEDIA_NONE);
    queue_op(OP_LOOKUP, 1'b0, 16'd0);
    queue_op(OP_LOOKUP, 1'b0, 16'hFFFF);
    queue_op(OP_LOOKUP, 1'b0, 16'd17);
    queue_op(OP_LOOKUP, 1'b1, 16'd5);
    queue_op(OP_FILL,   1'b0, 16'd0);
    queue_op(OP_FILL,   1'b0, 16'd0);
    queue_op(OP_LOOKUP, 1'b0, 16'd0);
    queue_op(OP_FILL,   1'b1, 16'hFFFF);
    queue_op(OP_LOOKUP, 1'b1, 16'hFFFF);
    queue_op(OP_LOOKUP, 1'b0, 16'hFFFF);
    // unknown type on one drive, the longest track on the other
    queue_media(4'd15, MEDIA_T5);
    queue_op(OP_LOOKUP, 1'b0, 16'd100);
    queue_op(OP_LOOKUP, 1'b1, 16'd71);
    queue_op(OP_LOOKUP, 1'b1, 16'hFFFE);
    queue_op(OP_LOOKUP, 1'b1, 16'hFFFF);
    queue_op(OP_FILL,   1'b1, 16'hFFFE);
    queue_op(OP_LOOKUP, 1'b1, 16'hFFFE);
    queue_op(OP_FILL,   1'b0, 16'hAAAA);
    queue_op(OP_FILL,   1'b1, 16'h5555);
    queue_op(OP_LOOKUP, 1'b0, 16'hAAAA);

    // random phases, each under its own pair of media types
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       begin d0 = MEDIA_T1;   d1 = MEDIA_T2;   end
        1:       begin d0 = MEDIA_T3;   d1 = MEDIA_T4;   end
        2:       begin d0 = MEDIA_T5;   d1 = 4'd15;      end
        3:       begin d0 = MEDIA_NONE; d1 = MEDIA_T5;   end
        4:       begin d0 = 4'd15;      d1 = MEDIA_NONE; end
        5:       begin d0 = MEDIA_T4;   d1 = MEDIA_T4;   end
        6:       begin d0 = MEDIA_T2;   d1 = 4'd9;       end
        7:       begin d0 = 4'd8;       d1 = MEDIA_T1;   end
        8:       begin
          d0 = TYPE_W'($urandom_range(0, 15));
          d1 = TYPE_W'($urandom_range(0, 15));
        end
        default: begin d0 = MEDIA_T5;   d1 = MEDIA_T3;   end
      endcase
      queue_media(d0, d1);
      phase_items = queued_n;
      while (queued_n - phase_items < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          // miss, fill, then hit on the same tag
          disk = 1'($urandom_range(0, 1));
          lba  = pick_lba();
          queue_op(OP_LOOKUP, disk, lba);
          queue_op(OP_FILL,   disk, lba);
          queue_op(OP_LOOKUP, disk, lba);
          remember_tag(disk, lba);
        end else if (roll < 65 && recent_tags.size() != 0) begin
          tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
          queue_op(OP_LOOKUP, tag[LBA_W], tag[LBA_W-1:0]);
        end else if (roll < 75 && recent_tags.size() != 0) begin
          // refill a tag that may already be present
          tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
          queue_op(OP_FILL, tag[LBA_W], tag[LBA_W-1:0]);
        end else if (roll < 88) begin
          queue_op(OP_LOOKUP, 1'($urandom_range(0, 1)), pick_lba());
        end else begin
          disk = 1'($urandom_range(0, 1));
          lba  = pick_lba();
          queue_op(OP_FILL, disk, lba);
          remember_tag(disk, lba);
        end
      end
    end

    // drain, then allow for the pipeline before closing
    while (pend_q.size() != 0 || start || result_q.size() != 0) @(posedge clk_i);
    repeat (WAYS + 8) @(posedge clk_i);
    if (error_n == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    int unsigned cycle_n;
    cycle_n = 0;
    while (cycle_n < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_n++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sclc_pkg.sv
rtl/sclc_cell.sv
rtl/sclc_geom.sv
rtl/sector_cache_lru_chs.sv
verif/tb_sector_cache_lru_chs.sv
